// File: hw/rtl/kmd_pkg.sv
// shared types, constants and key tables for the key matrix decoder
// no dependencies; used by every module of the block
`default_nettype none

package kmd_pkg;

    // register indexes of the configuration port
    localparam logic [7:0] REG_REPEAT_DELAY    = 8'd0;
    localparam logic [7:0] REG_REPEAT_INTERVAL = 8'd1;
    localparam logic [7:0] REG_RELEASE_POLLS   = 8'd2;
    localparam logic [7:0] REG_PRESS_POLLS     = 8'd3;

    // register reset values
    localparam logic [15:0] RST_REPEAT_DELAY    = 16'd1000;
    localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd200;
    localparam logic [7:0]  RST_RELEASE_POLLS   = 8'd20;
    localparam logic [7:0]  RST_PRESS_POLLS     = 8'd2;

    // modifier positions in the matrix
    localparam int unsigned POS_RCTRL  = 4;
    localparam int unsigned POS_LCTRL  = 20;
    localparam int unsigned POS_LSHIFT = 36;
    localparam int unsigned POS_FUNCT  = 44;
    localparam int unsigned POS_RSHIFT = 60;

    localparam logic [7:0] CTRL_MASK = 8'h1F;
    localparam logic [7:0] PEND_MAX  = 8'd255;

    // queue depth between front and back
    localparam int unsigned Q_DEPTH = 2;

    // plain key table, row-major
    localparam logic [7:0] TAB_PLAIN [64] = '{
        8'h37, 8'h6E, 8'h35, 8'h76, 8'h00, 8'h31, 8'h78, 8'h33,
        8'h6A, 8'h74, 8'h72, 8'h66, 8'h00, 8'h1B, 8'h71, 8'h64,
        8'h6D, 8'h36, 8'h62, 8'h34, 8'h00, 8'h7A, 8'h32, 8'h63,
        8'h6B, 8'h39, 8'h3B, 8'h2D, 8'h00, 8'h00, 8'h5C, 8'h27,
        8'h20, 8'h2C, 8'h2E, 8'h0B, 8'h00, 8'h08, 8'h0A, 8'h09,
        8'h75, 8'h69, 8'h6F, 8'h70, 8'h00, 8'h7F, 8'h5D, 8'h5B,
        8'h79, 8'h68, 8'h67, 8'h65, 8'h00, 8'h61, 8'h73, 8'h77,
        8'h38, 8'h6C, 8'h30, 8'h2F, 8'h00, 8'h0D, 8'h00, 8'h3D
    };

    // shifted key table, row-major
    localparam logic [7:0] TAB_UPPER [64] = '{
        8'h26, 8'h4E, 8'h25, 8'h56, 8'h00, 8'h21, 8'h58, 8'h23,
        8'h4A, 8'h54, 8'h52, 8'h46, 8'h00, 8'h1B, 8'h51, 8'h44,
        8'h4D, 8'h5E, 8'h42, 8'h24, 8'h00, 8'h5A, 8'h40, 8'h43,
        8'h4B, 8'h28, 8'h3A, 8'h5F, 8'h00, 8'h00, 8'h7C, 8'h22,
        8'h20, 8'h3C, 8'h3E, 8'h0B, 8'h00, 8'h08, 8'h0A, 8'h09,
        8'h55, 8'h49, 8'h4F, 8'h50, 8'h00, 8'h7F, 8'h7D, 8'h7B,
        8'h59, 8'h48, 8'h47, 8'h45, 8'h00, 8'h41, 8'h53, 8'h57,
        8'h2A, 8'h4C, 8'h29, 8'h3F, 8'h00, 8'h0D, 8'h00, 8'h2B
    };

    // function key table, row-major
    localparam logic [7:0] TAB_FN [64] = '{
        8'hB7, 8'h00, 8'hB5, 8'h00, 8'h00, 8'hB1, 8'h00, 8'hB3,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B, 8'h00, 8'h00,
        8'h00, 8'hB6, 8'h00, 8'hB4, 8'h00, 8'h00, 8'hB2, 8'h00,
        8'h00, 8'hB9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hB8, 8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // one classified poll
    typedef struct packed {
        logic [7:0] ch;
        logic       sh;
        logic       ct;
        logic       fn;
    } t_dec;

    // configuration registers
    typedef struct packed {
        logic [15:0] repeat_delay;
        logic [15:0] repeat_interval;
        logic [7:0]  release_polls;
        logic [7:0]  press_polls;
    } t_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/kmd_front.sv
// front end: modifier flags and first-key decode of one matrix snapshot
// depends on kmd_pkg (tables, t_dec)
`default_nettype none

module kmd_front (
    input  wire logic [63:0] i_key_matrix,
    output kmd_pkg::t_dec    o_dec
);
    import kmd_pkg::*;

    logic        sh;
    logic        ct;
    logic        fn;
    logic [63:0] hit;
    logic [63:0] first;
    logic [7:0]  ch;
    logic [7:0]  sel [64];

    // modifier flags
    assign sh = i_key_matrix[POS_LSHIFT] | i_key_matrix[POS_RSHIFT];
    assign ct = i_key_matrix[POS_LCTRL] | i_key_matrix[POS_RCTRL];
    assign fn = i_key_matrix[POS_FUNCT];

    // per-position table entry and hit flag
    always_comb begin
        for (int p = 0; p < 64; p++) begin
            if (fn) begin
                sel[p] = TAB_FN[p];
            end else if (sh) begin
                sel[p] = TAB_UPPER[p];
            end else begin
                sel[p] = TAB_PLAIN[p];
            end
            hit[p] = i_key_matrix[p] && (sel[p] != 8'd0)
                     && (p != POS_LSHIFT) && (p != POS_RSHIFT)
                     && (p != POS_LCTRL) && (p != POS_RCTRL)
                     && (p != POS_FUNCT);
        end
    end

    // isolate lowest hit and select its entry
    assign first = hit & (~hit + 64'd1);

    always_comb begin
        ch = 8'd0;
        for (int p = 0; p < 64; p++) begin
            ch = ch | (first[p] ? sel[p] : 8'd0);
        end
    end

    // ctrl folds letters to control codes
    always_comb begin
        o_dec.sh = sh;
        o_dec.ct = ct;
        o_dec.fn = fn;
        o_dec.ch = ch;
        if (ct && (((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A)))) begin
            o_dec.ch = ch & CTRL_MASK;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/kmd_queue.sv
// short queue of classified polls between front and back
// depends on kmd_pkg (t_dec, Q_DEPTH)
`default_nettype none

module kmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire kmd_pkg::t_dec i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output kmd_pkg::t_dec      o_data
);
    import kmd_pkg::*;

    localparam int unsigned PW = $clog2(Q_DEPTH);
    localparam int unsigned CW = $clog2(Q_DEPTH + 1);

    t_dec          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/kmd_back.sv
// back end: press/release debounce, typematic repeat, output register
// depends on kmd_pkg (t_dec, t_cfg)
`default_nettype none

module kmd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kmd_pkg::t_cfg i_cfg,
    input  wire logic          i_q_empty,
    input  wire kmd_pkg::t_dec i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [7:0]         o_key_code,
    output logic               o_shift_held,
    output logic               o_ctrl_held,
    output logic               o_funct_held
);
    import kmd_pkg::*;

    logic [7:0]  r_held;
    logic [15:0] r_rep;
    logic [7:0]  r_rel;
    logic [7:0]  r_pkey;
    logic [7:0]  r_pcnt;
    logic [7:0]  n_held;
    logic [15:0] n_rep;
    logic [7:0]  n_rel;
    logic [7:0]  n_pkey;
    logic [7:0]  n_pcnt;
    logic [7:0]  n_code;
    logic [7:0]  cnt;
    logic        r_valid;
    logic [7:0]  r_code;
    logic        r_sh;
    logic        r_ct;
    logic        r_fn;
    logic [7:0]  ch;

    assign ch = i_q_data.ch;

    // take a word when the output register is free or being drained
    assign o_q_pop = !i_q_empty && (!r_valid || !i_out_stall);

    // debounce and repeat step
    always_comb begin
        n_held = r_held;
        n_rep  = r_rep;
        n_rel  = r_rel;
        n_pkey = r_pkey;
        n_pcnt = r_pcnt;
        n_code = 8'd0;
        cnt    = 8'd1;
        if (ch == 8'd0) begin
            if (r_rel != 8'd0) begin
                n_rel = r_rel - 8'd1;
            end else begin
                n_held = 8'd0;
                n_rep  = 16'd0;
            end
        end else begin
            n_rel = i_cfg.release_polls;
            if (ch == r_held) begin
                n_pkey = 8'd0;
                n_pcnt = 8'd0;
                if (r_rep == 16'd0) begin
                    n_rep  = i_cfg.repeat_interval;
                    n_code = ch;
                end else begin
                    n_rep = r_rep - 16'd1;
                end
            end else begin
                if (ch == r_pkey) begin
                    cnt = (r_pcnt == PEND_MAX) ? r_pcnt : r_pcnt + 8'd1;
                end
                if (cnt >= i_cfg.press_polls) begin
                    n_held = ch;
                    n_rep  = i_cfg.repeat_delay;
                    n_pkey = 8'd0;
                    n_pcnt = 8'd0;
                    n_code = ch;
                end else begin
                    n_pkey = ch;
                    n_pcnt = cnt;
                end
            end
        end
    end

    // debounce state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 8'd0;
            r_rep  <= 16'd0;
            r_rel  <= 8'd0;
            r_pkey <= 8'd0;
            r_pcnt <= 8'd0;
        end else if (o_q_pop) begin
            r_held <= n_held;
            r_rep  <= n_rep;
            r_rel  <= n_rel;
            r_pkey <= n_pkey;
            r_pcnt <= n_pcnt;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_code <= n_code;
            r_sh   <= i_q_data.sh;
            r_ct   <= i_q_data.ct;
            r_fn   <= i_q_data.fn;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_key_code   = r_code;
    assign o_shift_held = r_sh;
    assign o_ctrl_held  = r_ct;
    assign o_funct_held = r_fn;

endmodule

`default_nettype wire

// File: hw/rtl/key_matrix_decode_debounce_repeat.sv
// top level of the key matrix decoder: configuration registers and wiring
// depends on kmd_pkg, kmd_front, kmd_queue, kmd_back
`default_nettype none

// Takes one 64-bit key matrix snapshot per cycle and returns one word per
// snapshot: the reported key code (0 for no event) and the shift, ctrl and
// function flags of that snapshot. The decoder front end classifies a
// snapshot combinationally and pushes it into a two-word queue; the back end
// pops one word per cycle unless the output stalls, runs the debounce and
// repeat step and registers the result, so the sustained rate is one poll
// per cycle; o_out_valid comes from the output register behind the queue.
// The input stalls only when the queue is full. Configuration writes are
// always accepted (o_cfg_ready is high); indexes above three are ignored.
module key_matrix_decode_debounce_repeat (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_key_matrix,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_key_code,
    output logic             o_shift_held,
    output logic             o_ctrl_held,
    output logic             o_funct_held,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import kmd_pkg::*;

    t_cfg r_cfg;
    t_dec front_dec;
    t_dec q_data;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_delay    <= RST_REPEAT_DELAY;
            r_cfg.repeat_interval <= RST_REPEAT_INTERVAL;
            r_cfg.release_polls   <= RST_RELEASE_POLLS;
            r_cfg.press_polls     <= RST_PRESS_POLLS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_REPEAT_DELAY:    r_cfg.repeat_delay    <= i_cfg_data;
                REG_REPEAT_INTERVAL: r_cfg.repeat_interval <= i_cfg_data;
                REG_RELEASE_POLLS:   r_cfg.release_polls   <= i_cfg_data[7:0];
                REG_PRESS_POLLS:     r_cfg.press_polls     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // decode front end
    kmd_front u_front (
        .i_key_matrix (i_key_matrix),
        .o_dec        (front_dec)
    );

    // queue between front and back
    kmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_dec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // debounce and repeat back end
    kmd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (q_empty),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_code   (o_key_code),
        .o_shift_held (o_shift_held),
        .o_ctrl_held  (o_ctrl_held),
        .o_funct_held (o_funct_held)
    );

endmodule

`default_nettype wire
